// File: hw/rtl/vde_pkg.sv
// Shared types, constants and the ratio-to-angle table of the vibration
// direction estimator. No dependencies.
`timescale 1ns / 1ps

package vde_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int NUM_CH           = 3;
    localparam int CFG_IDX_W        = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

    localparam logic [7:0] MARGIN_RST  = 8'd10;
    localparam logic [7:0] TIMEOUT_RST = 8'd100;

    // Sensor numbers as kept by the arrival tracker.
    localparam logic [1:0] SENSOR_NONE  = 2'd0;
    localparam logic [1:0] SENSOR_ONE   = 2'd1;
    localparam logic [1:0] SENSOR_TWO   = 2'd2;
    localparam logic [1:0] SENSOR_THREE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMB_WR,
        ST_AMB_MUL,
        ST_AMB_FIX,
        ST_DET,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Baseline update steps of a lane.
    typedef struct packed {
        logic wr;
        logic mul;
        logic fix;
    } lane_ctrl_t;

    typedef struct packed {
        logic eval;
        logic step;
    } trk_ctrl_t;

    typedef struct packed {
        logic compute_req;
        logic div_done;
    } trk_stat_t;

    typedef struct packed {
        logic       ok;
        logic [8:0] angle;
        logic [7:0] amplitude;
        logic [1:0] first;
        logic [1:0] second;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] deg;
    } base_t;

    // Base angle for an arrival-time ratio given in tenths.
    function automatic base_t base_angle(input logic [3:0] tenths);
        base_t b;
        b.valid = 1'b1;
        case (tenths)
            4'd10:   b.deg = 6'd0;
            4'd9:    b.deg = 6'd5;
            4'd8:    b.deg = 6'd10;
            4'd7:    b.deg = 6'd20;
            4'd6:    b.deg = 6'd25;
            4'd5:    b.deg = 6'd30;
            4'd4:    b.deg = 6'd35;
            4'd3:    b.deg = 6'd40;
            4'd2:    b.deg = 6'd50;
            4'd1:    b.deg = 6'd55;
            4'd0:    b.deg = 6'd60;
            default: begin
                b.valid = 1'b0;
                b.deg   = 6'd0;
            end
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/vde_lane.sv
// One sensor lane: sliding window memory, running sum, baseline mean and
// the arrival compare. Depends on vde_pkg.
`timescale 1ns / 1ps

module vde_lane #(
    parameter int WINDOW_DEPTH = vde_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic [7:0]                      sample_in,
    input  vde_pkg::lane_ctrl_t             ctrl,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] idx,
    input  logic [7:0]                      margin,
    output logic [7:0]                      level,
    output logic                            arrive
);

    localparam int SUM_W   = $clog2(255 * WINDOW_DEPTH + 1);
    localparam int RECIP_K = SUM_W;
    localparam int PROD_W  = SUM_W + RECIP_K;
    localparam logic [RECIP_K-1:0] RECIP_M = RECIP_K'((2 ** RECIP_K) / WINDOW_DEPTH);
    localparam logic [SUM_W-1:0]   DEPTH_V = SUM_W'(WINDOW_DEPTH);

    logic [7:0]              win_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] vld_reg;
    logic [7:0]              sample_reg;
    logic [7:0]              rd_data_reg;
    logic                    rd_vld_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [7:0]              qest_reg;
    logic [7:0]              qest_next;
    logic [7:0]              base_reg;
    logic [7:0]              base_next;
    logic [7:0]              old_val;
    logic [PROD_W-1:0]       prod;
    logic [SUM_W-1:0]        rem;

    // Window memory with a registered read at the current slot.
    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            win_mem[idx] <= sample_reg;
        end
        rd_data_reg <= win_mem[idx];
        rd_vld_reg  <= vld_reg[idx];
        if (load) begin
            sample_reg <= sample_in;
        end
        if (ctrl.mul) begin
            qest_reg <= qest_next;
        end
    end

    // A slot never written reads as zero.
    assign old_val  = rd_vld_reg ? rd_data_reg : 8'd0;
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);

    // Mean by reciprocal multiply; the estimate is low by at most one.
    assign prod      = PROD_W'(sum_reg) * PROD_W'(RECIP_M);
    assign qest_next = prod[RECIP_K +: 8];
    assign rem       = sum_reg - SUM_W'(qest_reg) * DEPTH_V;
    assign base_next = (rem >= DEPTH_V) ? qest_reg + 8'd1 : qest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            sum_reg  <= '0;
            base_reg <= 8'd0;
        end else begin
            if (ctrl.wr) begin
                vld_reg[idx] <= 1'b1;
                sum_reg      <= sum_next;
            end
            if (ctrl.fix) begin
                base_reg <= base_next;
            end
        end
    end

    // Arrival: reading strictly above baseline plus margin, at 9 bits.
    assign arrive = {1'b0, sample_reg} > ({1'b0, base_reg} + {1'b0, margin});
    assign level  = sample_reg;

endmodule

// File: hw/rtl/vde_tracker.sv
// Merging stage: three-phase arrival tracker, ratio divider, angle and
// amplitude of the finished event. Depends on vde_pkg.
`timescale 1ns / 1ps

module vde_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vde_pkg::trk_ctrl_t   ctrl,
    input  logic [2:0]           arrive,
    input  logic [2:0][7:0]      levels,
    input  logic [7:0]           timeout_limit,
    output vde_pkg::trk_stat_t   stat,
    output vde_pkg::result_t     result
);

    localparam logic [8:0] ANGLE_FULL = 9'd360;
    localparam logic [8:0] ANGLE_A    = 9'd120;
    localparam logic [8:0] ANGLE_B    = 9'd240;
    localparam logic [19:0] DIV3_MUL  = 20'd683;
    localparam int DIV3_SHIFT         = 11;

    logic [1:0]      first_reg, first_next;
    logic [1:0]      second_reg, second_next;
    logic [7:0]      c2_reg, c2_next;
    logic [7:0]      c3_reg, c3_next;
    logic [2:0][7:0] lvl_reg, lvl_next;
    logic [1:0]      pf_reg, ps_reg;
    logic [11:0]     rem_reg;
    logic [7:0]      div_reg;
    logic [3:0]      q_reg;
    logic            ovf_reg;
    logic            dz_reg;
    logic [1:0]      step_reg;

    logic [7:0]      c2b, c3b;
    logic [2:0]      total;
    logic [1:0]      third_ch;
    logic            bad;
    logic            found;
    logic            compute_req;
    logic [11:0]     dsh;
    logic            ge;
    vde_pkg::base_t  base;
    logic [8:0]      a9;
    logic [8:0]      angle;
    logic            pair_ok;
    logic [9:0]      asum;
    logic [19:0]     aprod;

    function automatic logic [7:0] bump(input logic [7:0] c);
        return (c != 8'hFF) ? c + 8'd1 : c;
    endfunction

    assign c2b      = bump(c2_reg);
    assign c3b      = bump(c3_reg);
    assign total    = {1'b0, first_reg} + {1'b0, second_reg};
    assign third_ch = 2'(3'd5 - total);
    assign bad      = (c3b >= timeout_limit) || (first_reg == second_reg) ||
                      (total < 3'd3) || (total > 3'd5);

    // Tracker update for one detection item.
    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        c2_next     = c2_reg;
        c3_next     = c3_reg;
        lvl_next    = lvl_reg;
        compute_req = 1'b0;
        found       = 1'b0;
        if (ctrl.eval) begin
            if (first_reg == vde_pkg::SENSOR_NONE) begin
                for (int ch = 0; ch < vde_pkg::NUM_CH; ch++) begin
                    if (!found && arrive[ch]) begin
                        found        = 1'b1;
                        first_next   = 2'(ch + 1);
                        lvl_next[ch] = levels[ch];
                    end
                end
            end else if (second_reg == vde_pkg::SENSOR_NONE) begin
                c2_next = c2b;
                c3_next = c3b;
                if (c2b >= timeout_limit) begin
                    first_next = vde_pkg::SENSOR_NONE;
                    c2_next    = 8'd0;
                    c3_next    = 8'd0;
                end else begin
                    for (int ch = 0; ch < vde_pkg::NUM_CH; ch++) begin
                        if (!found && (2'(ch + 1) != first_reg) && arrive[ch]) begin
                            found        = 1'b1;
                            second_next  = 2'(ch + 1);
                            lvl_next[ch] = levels[ch];
                        end
                    end
                end
            end else begin
                c3_next = c3b;
                if (bad || arrive[third_ch]) begin
                    if (!bad) begin
                        lvl_next[third_ch] = levels[third_ch];
                        compute_req        = 1'b1;
                    end
                    first_next  = vde_pkg::SENSOR_NONE;
                    second_next = vde_pkg::SENSOR_NONE;
                    c2_next     = 8'd0;
                    c3_next     = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= vde_pkg::SENSOR_NONE;
            second_reg <= vde_pkg::SENSOR_NONE;
            c2_reg     <= 8'd0;
            c3_reg     <= 8'd0;
            lvl_reg    <= '0;
            step_reg   <= 2'd0;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
            c2_reg     <= c2_next;
            c3_reg     <= c3_next;
            lvl_reg    <= lvl_next;
            if (compute_req) begin
                step_reg <= 2'd3;
            end else if (ctrl.step) begin
                step_reg <= step_reg - 2'd1;
            end
        end
    end

    // Restoring division of 10 * count_to_second by count_to_third, one
    // quotient bit per cycle; a quotient of 16 or more is flagged.
    assign dsh = 12'(div_reg) << step_reg;
    assign ge  = rem_reg >= dsh;

    always_ff @(posedge aclk) begin
        if (compute_req) begin
            pf_reg  <= first_reg;
            ps_reg  <= second_reg;
            rem_reg <= 12'(c2_reg) * 12'd10;
            div_reg <= c3b;
            dz_reg  <= (c3b == 8'd0);
            ovf_reg <= 1'b0;
            q_reg   <= 4'd0;
        end else if (ctrl.step) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh;
            end
            q_reg[step_reg] <= ge;
            if (step_reg == 2'd3) begin
                ovf_reg <= rem_reg >= {div_reg, 4'b0000};
            end
        end
    end

    // Angle from the ratio and the order of the first two arrivals.
    always_comb begin
        base    = vde_pkg::base_angle(q_reg);
        a9      = 9'(base.deg);
        pair_ok = 1'b1;
        angle   = 9'd0;
        if (pf_reg == vde_pkg::SENSOR_ONE && ps_reg == vde_pkg::SENSOR_TWO) begin
            angle = a9;
        end else if (pf_reg == vde_pkg::SENSOR_ONE && ps_reg == vde_pkg::SENSOR_THREE) begin
            angle = ANGLE_FULL - a9;
        end else if (pf_reg == vde_pkg::SENSOR_TWO && ps_reg == vde_pkg::SENSOR_ONE) begin
            angle = ANGLE_A - a9;
        end else if (pf_reg == vde_pkg::SENSOR_TWO && ps_reg == vde_pkg::SENSOR_THREE) begin
            angle = ANGLE_A + a9;
        end else if (pf_reg == vde_pkg::SENSOR_THREE && ps_reg == vde_pkg::SENSOR_ONE) begin
            angle = ANGLE_B + a9;
        end else if (pf_reg == vde_pkg::SENSOR_THREE && ps_reg == vde_pkg::SENSOR_TWO) begin
            angle = ANGLE_B - a9;
        end else begin
            pair_ok = 1'b0;
        end
    end

    // Mean of the three levels by reciprocal multiply, exact below 768.
    assign asum  = 10'(lvl_reg[0]) + 10'(lvl_reg[1]) + 10'(lvl_reg[2]);
    assign aprod = 20'(asum) * DIV3_MUL;

    assign result.ok        = base.valid && pair_ok && !ovf_reg && !dz_reg;
    assign result.angle     = angle;
    assign result.amplitude = aprod[DIV3_SHIFT +: 8];
    assign result.first     = pf_reg;
    assign result.second    = ps_reg;

    assign stat.compute_req = compute_req;
    assign stat.div_done    = ctrl.step && (step_reg == 2'd0);

endmodule

// File: hw/rtl/vibration_direction_estimator_unit.sv
// Top level of the vibration direction estimator: control sequencer,
// configuration registers, three lanes, tracker and output register.
// Depends on vde_pkg, vde_lane and vde_tracker.
//
//   Channel  Ports                                      Direction
//   input    s_valid/s_ready, s_req_type, s_sample_*    in
//   result   m_valid/m_ready, m_angle_degrees, ...      out
//   config   cfg_valid/cfg_ready, cfg_index, cfg_data   in
//
// An ambient item goes through transfer, window write and sum update,
// reciprocal multiply and mean correction. A detection item goes through
// transfer and evaluation and, if it completes an event, the ratio divider,
// one bit a cycle, and the result register load. The output register
// lets the next item in while a result waits; a second result waits in the
// load cycle until the first is taken. Reset clears windows, baselines
// and tracker at once; configuration writes are taken in any cycle.
`timescale 1ns / 1ps

module vibration_direction_estimator_unit #(
    parameter int WINDOW_DEPTH = vde_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [7:0]                    s_sample_one,
    input  logic [7:0]                    s_sample_two,
    input  logic [7:0]                    s_sample_three,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [8:0]                    m_angle_degrees,
    output logic [7:0]                    m_amplitude,
    output logic [1:0]                    m_first_sensor,
    output logic [1:0]                    m_second_sensor,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);

    vde_pkg::state_t     state_reg, state_next;
    vde_pkg::lane_ctrl_t lane_ctrl;
    vde_pkg::trk_ctrl_t  trk_ctrl;
    vde_pkg::trk_stat_t  trk_stat;
    vde_pkg::result_t    result;

    logic [7:0]       margin_reg;
    logic [7:0]       timeout_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             in_xfer;
    logic             out_free;
    logic             out_load;
    logic [2:0]       arrive;
    logic [2:0][7:0]  levels;
    logic [7:0]       sample_in [3];

    logic             m_valid_reg;
    logic [8:0]       m_angle_reg;
    logic [7:0]       m_amp_reg;
    logic [1:0]       m_first_reg;
    logic [1:0]       m_second_reg;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vde_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_req_type ? vde_pkg::ST_DET : vde_pkg::ST_AMB_WR;
                end
            end
            vde_pkg::ST_AMB_WR:  state_next = vde_pkg::ST_AMB_MUL;
            vde_pkg::ST_AMB_MUL: state_next = vde_pkg::ST_AMB_FIX;
            vde_pkg::ST_AMB_FIX: state_next = vde_pkg::ST_IDLE;
            vde_pkg::ST_DET: begin
                state_next = trk_stat.compute_req ? vde_pkg::ST_DIV : vde_pkg::ST_IDLE;
            end
            vde_pkg::ST_DIV: begin
                if (trk_stat.div_done) begin
                    state_next = vde_pkg::ST_EMIT;
                end
            end
            vde_pkg::ST_EMIT: begin
                if (!result.ok || out_free) begin
                    state_next = vde_pkg::ST_IDLE;
                end
            end
            default: state_next = vde_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready       = (state_reg == vde_pkg::ST_IDLE);
        lane_ctrl.wr  = (state_reg == vde_pkg::ST_AMB_WR);
        lane_ctrl.mul = (state_reg == vde_pkg::ST_AMB_MUL);
        lane_ctrl.fix = (state_reg == vde_pkg::ST_AMB_FIX);
        trk_ctrl.eval = (state_reg == vde_pkg::ST_DET);
        trk_ctrl.step = (state_reg == vde_pkg::ST_DIV);
        out_load      = (state_reg == vde_pkg::ST_EMIT) && result.ok && out_free;
    end

    // State, window slot, configuration and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vde_pkg::ST_IDLE;
            idx_reg     <= '0;
            margin_reg  <= vde_pkg::MARGIN_RST;
            timeout_reg <= vde_pkg::TIMEOUT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (lane_ctrl.wr) begin
                idx_reg <= (idx_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    vde_pkg::CFG_MARGIN:  margin_reg  <= cfg_data;
                    vde_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_angle_reg  <= result.angle;
            m_amp_reg    <= result.amplitude;
            m_first_reg  <= result.first;
            m_second_reg <= result.second;
        end
    end

    assign sample_in[0] = s_sample_one;
    assign sample_in[1] = s_sample_two;
    assign sample_in[2] = s_sample_three;

    // One lane per sensor.
    for (genvar ch = 0; ch < vde_pkg::NUM_CH; ch++) begin : g_lane
        vde_lane #(
            .WINDOW_DEPTH(WINDOW_DEPTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (in_xfer),
            .sample_in (sample_in[ch]),
            .ctrl      (lane_ctrl),
            .idx       (idx_reg),
            .margin    (margin_reg),
            .level     (levels[ch]),
            .arrive    (arrive[ch])
        );
    end

    vde_tracker u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (trk_ctrl),
        .arrive        (arrive),
        .levels        (levels),
        .timeout_limit (timeout_reg),
        .stat          (trk_stat),
        .result        (result)
    );

    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_angle_degrees = m_angle_reg;
    assign m_amplitude     = m_amp_reg;
    assign m_first_sensor  = m_first_reg;
    assign m_second_sensor = m_second_reg;

endmodule

// File: tb/vibration_direction_estimator_unit_tb.sv
// Self-checking testbench for vibration_direction_estimator_unit: directed and random
// sensor items, with a built-in predictor of baselines, arrival tracking and direction.
// Depends on vde_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module vibration_direction_estimator_unit_tb;
    import vde_pkg::*;

    localparam int DEPTH       = WINDOW_DEPTH_DEF;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic REQ_AMBIENT = 1'b0;
    localparam logic REQ_DETECT  = 1'b1;

    localparam int LVL_QUIET = 0;
    localparam int LVL_HOT   = 1;
    localparam int LVL_ANY   = 2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] s_one;
        logic [7:0] s_two;
        logic [7:0] s_three;
    } sample_t;

    typedef struct packed {
        logic [8:0] angle;
        logic [7:0] amplitude;
        logic [1:0] first_sensor;
        logic [1:0] second_sensor;
    } bearing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [7:0] s_sample_one = 8'd0;
    logic [7:0] s_sample_two = 8'd0;
    logic [7:0] s_sample_three = 8'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [8:0] m_angle_degrees;
    logic [7:0] m_amplitude;
    logic [1:0] m_first_sensor;
    logic [1:0] m_second_sensor;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MARGIN;
    logic [7:0] cfg_data = 8'd0;

    // Stimulus and scoreboard bookkeeping.
    sample_t  sample_backlog[$];
    bearing_t expected_bearings[$];
    int queued_count = 0;
    int taken_count = 0;
    int result_count = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int idle_pct = 16;
    bit in_taken = 1'b0;

    // Predictor state.
    logic [7:0] cut_margin;
    logic [7:0] timeout_lim;
    logic [7:0] win_hist [3][DEPTH];
    int         chan_sum [3];
    int         win_ptr;
    logic [1:0] hit_first;
    logic [1:0] hit_second;
    logic [7:0] cnt_second;
    logic [7:0] cnt_third;
    logic [7:0] cross_lvl [3];

    vibration_direction_estimator_unit #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_sample_one(s_sample_one),
        .s_sample_two(s_sample_two),
        .s_sample_three(s_sample_three),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_angle_degrees(m_angle_degrees),
        .m_amplitude(m_amplitude),
        .m_first_sensor(m_first_sensor),
        .m_second_sensor(m_second_sensor),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_model();
        int ch, k;
        cut_margin  = MARGIN_RST;
        timeout_lim = TIMEOUT_RST;
        for (ch = 0; ch < 3; ch++) begin
            chan_sum[ch]  = 0;
            cross_lvl[ch] = 8'd0;
            for (k = 0; k < DEPTH; k++) win_hist[ch][k] = 8'd0;
        end
        win_ptr = 0;
        clear_tracker();
    endtask

    task automatic clear_tracker();
        hit_first  = SENSOR_NONE;
        hit_second = SENSOR_NONE;
        cnt_second = 8'd0;
        cnt_third  = 8'd0;
    endtask

    // The baseline plus margin is formed wide, so it never wraps.
    function automatic bit over_baseline(input int ch, input logic [7:0] v);
        return int'(v) > chan_sum[ch] / DEPTH + int'(cut_margin);
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == 8'd255) ? c : c + 8'd1;
    endfunction

    // Advances the windows or the tracker by one accepted item and queues any direction it yields.
    task automatic track_arrivals(input sample_t it);
        logic [7:0] v [3];
        int ch, slot, total, tenths, base, angle;
        bit found;
        bearing_t r;
        v[0] = it.s_one;
        v[1] = it.s_two;
        v[2] = it.s_three;
        found = 1'b0;
        if (it.req_type == REQ_AMBIENT) begin
            slot = win_ptr;
            for (ch = 0; ch < 3; ch++) begin
                chan_sum[ch] = chan_sum[ch] - int'(win_hist[ch][slot]) + int'(v[ch]);
                win_hist[ch][slot] = v[ch];
            end
            win_ptr = (slot + 1 >= DEPTH) ? 0 : slot + 1;
        end else if (hit_first == SENSOR_NONE) begin
            for (ch = 0; ch < 3; ch++) begin
                if (!found && over_baseline(ch, v[ch])) begin
                    found = 1'b1;
                    hit_first = 2'(ch + 1);
                    cross_lvl[ch] = v[ch];
                end
            end
        end else if (hit_second == SENSOR_NONE) begin
            cnt_second = sat_inc(cnt_second);
            cnt_third  = sat_inc(cnt_third);
            if (cnt_second >= timeout_lim) begin
                clear_tracker();
            end else begin
                for (ch = 0; ch < 3; ch++) begin
                    if (!found && ch + 1 != hit_first && over_baseline(ch, v[ch])) begin
                        found = 1'b1;
                        hit_second = 2'(ch + 1);
                        cross_lvl[ch] = v[ch];
                    end
                end
            end
        end else begin
            total = hit_first + hit_second;
            cnt_third = sat_inc(cnt_third);
            if (cnt_third >= timeout_lim || hit_first == hit_second || total < 3 || total > 5) begin
                clear_tracker();
            end else begin
                ch = 5 - total;
                if (over_baseline(ch, v[ch])) begin
                    cross_lvl[ch] = v[ch];
                    if (cnt_third != 8'd0) begin
                        tenths = (10 * int'(cnt_second)) / int'(cnt_third);
                        case (tenths)
                            10:      base = 0;
                            9:       base = 5;
                            8:       base = 10;
                            7:       base = 20;
                            6:       base = 25;
                            5:       base = 30;
                            4:       base = 35;
                            3:       base = 40;
                            2:       base = 50;
                            1:       base = 55;
                            0:       base = 60;
                            default: base = -1;
                        endcase
                        angle = -1;
                        if (base >= 0) begin
                            case ({hit_first, hit_second})
                                {SENSOR_ONE, SENSOR_TWO}:   angle = base;
                                {SENSOR_ONE, SENSOR_THREE}: angle = 360 - base;
                                {SENSOR_TWO, SENSOR_ONE}:   angle = 120 - base;
                                {SENSOR_TWO, SENSOR_THREE}: angle = 120 + base;
                                {SENSOR_THREE, SENSOR_ONE}: angle = 240 + base;
                                {SENSOR_THREE, SENSOR_TWO}: angle = 240 - base;
                                default:                    angle = -1;
                            endcase
                        end
                        if (angle >= 0) begin
                            r.angle = 9'(angle);
                            r.amplitude = 8'((int'(cross_lvl[0]) + int'(cross_lvl[1])
                                              + int'(cross_lvl[2])) / 3);
                            r.first_sensor  = hit_first;
                            r.second_sensor = hit_second;
                            expected_bearings.push_back(r);
                        end
                    end
                    clear_tracker();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: payload changes on the falling edge, transfers are seen on the rising edge.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        sample_t it;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            it.req_type = s_req_type;
            it.s_one    = s_sample_one;
            it.s_two    = s_sample_two;
            it.s_three  = s_sample_three;
            track_arrivals(it);
            taken_count++;
        end
    end

    always @(negedge aclk) begin
        sample_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = sample_backlog.pop_front();
                s_valid        <= 1'b1;
                s_req_type     <= nxt.req_type;
                s_sample_one   <= nxt.s_one;
                s_sample_two   <= nxt.s_two;
                s_sample_three <= nxt.s_three;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls.
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        bearing_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.angle         = m_angle_degrees;
            got.amplitude     = m_amplitude;
            got.first_sensor  = m_first_sensor;
            got.second_sensor = m_second_sensor;
            if (expected_bearings.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: result %0d arrived with none expected: angle=%0d amp=%0d first=%0d second=%0d",
                             result_count, got.angle, got.amplitude,
                             got.first_sensor, got.second_sensor);
                mismatches++;
            end else begin
                want = expected_bearings.pop_front();
                if (got.angle !== want.angle || got.amplitude !== want.amplitude ||
                    got.first_sensor !== want.first_sensor ||
                    got.second_sensor !== want.second_sensor) begin
                    if (mismatches < 10)
                        $display("ERROR: result %0d expected angle=%0d amp=%0d first=%0d second=%0d, got angle=%0d amp=%0d first=%0d second=%0d",
                                 result_count, want.angle, want.amplitude,
                                 want.first_sensor, want.second_sensor, got.angle,
                                 got.amplitude, got.first_sensor, got.second_sensor);
                    mismatches++;
                end
            end
            result_count++;
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("vibration_direction_estimator_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_sample(input logic rt, input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c);
        sample_t it;
        it.req_type = rt;
        it.s_one    = a;
        it.s_two    = b;
        it.s_three  = c;
        sample_backlog.push_back(it);
        queued_count++;
    endtask

    // Quiet levels lie in 0 to 8; hot levels start at 70 plus the margin, capped at 255.
    function automatic logic [7:0] pick_level(input int kind);
        int hot_lo;
        hot_lo = 70 + int'(cut_margin);
        if (hot_lo > 255) hot_lo = 255;
        case (kind)
            LVL_QUIET: return 8'($urandom_range(8));
            LVL_HOT:   return 8'($urandom_range(255, hot_lo));
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_ambient();
        queue_sample(REQ_AMBIENT, 8'($urandom_range(60)), 8'($urandom_range(60)),
                     8'($urandom_range(60)));
    endtask

    // One vibration event: three arrivals in random order with random quiet gaps.
    // About one in ten events is cut short after the first or second arrival.
    task automatic queue_event(input int gap_max);
        int order [3];
        int kinds [3];
        int stage, j, stop_at;
        order[0] = $urandom_range(2);
        order[1] = (order[0] + 1 + $urandom_range(1)) % 3;
        order[2] = 3 - order[0] - order[1];
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 3;
        repeat ($urandom_range(2)) queue_ambient();
        for (stage = 0; stage < stop_at; stage++) begin
            if (stage > 0) begin
                repeat ($urandom_range(gap_max)) begin
                    if ($urandom_range(7) == 0)
                        queue_ambient();
                    else
                        queue_sample(REQ_DETECT, pick_level(LVL_QUIET), pick_level(LVL_QUIET),
                                     pick_level(LVL_QUIET));
                end
            end
            for (j = 0; j < 3; j++)
                kinds[order[j]] = (j < stage) ? LVL_ANY : ((j == stage) ? LVL_HOT : LVL_QUIET);
            queue_sample(REQ_DETECT, pick_level(kinds[0]), pick_level(kinds[1]),
                         pick_level(kinds[2]));
        end
    endtask

    // Mostly well-formed events, the rest fully random items.
    task automatic queue_random(input int n_items, input int gap_max);
        int start;
        start = queued_count;
        while (queued_count - start < n_items) begin
            if ($urandom_range(4) == 0)
                queue_sample(1'($urandom_range(1)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
            else
                queue_event(gap_max);
        end
    endtask

    // Waits until every item is taken and every result has arrived, then lets the
    // block finish any item that produced no result.
    task automatic drain();
        while (taken_count != queued_count || expected_bearings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MARGIN)
            cut_margin = val;
        else if (idx == CFG_TIMEOUT)
            timeout_lim = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        int tmo;
        reset_model();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part with reset settings: empty windows, margin boundary,
        // an event with no gaps between arrivals, ambient items inside an event, and all six hit orders.
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd10, 8'd10, 8'd10);
        queue_sample(REQ_DETECT, 8'd11, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd255, 8'd255, 8'd255);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd255);
        queue_sample(REQ_AMBIENT, 8'd20, 8'd40, 8'd60);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd200);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd100, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd0);
        queue_sample(REQ_AMBIENT, 8'd0, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd90, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd250, 8'd0);
        queue_sample(REQ_DETECT, 8'd250, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd250);
        queue_sample(REQ_DETECT, 8'd0, 8'd250, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd250);
        queue_sample(REQ_DETECT, 8'd250, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd250);
        queue_sample(REQ_DETECT, 8'd250, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd250, 8'd0);
        queue_sample(REQ_DETECT, 8'd250, 8'd0, 8'd0);
        queue_sample(REQ_DETECT, 8'd0, 8'd0, 8'd250);
        queue_sample(REQ_DETECT, 8'd0, 8'd250, 8'd0);
        queue_random(200, 12);
        drain();

        // Zero margin and the longest timeout, with no idling on either side.
        idle_pct = 0;
        write_reg(CFG_MARGIN, 8'd0);
        write_reg(CFG_TIMEOUT, 8'd255);
        queue_random(180, 14);
        drain();
        idle_pct = 16;

        // Full margin: nothing can arrive, even at full scale. Shortest timeout.
        write_reg(CFG_MARGIN, 8'd255);
        write_reg(CFG_TIMEOUT, 8'd1);
        queue_sample(REQ_DETECT, 8'd255, 8'd255, 8'd255);
        queue_random(40, 3);
        drain();

        // Short timeouts that cut many events; the sender holds off halfway
        // until every result is back.
        tmo = $urandom_range(20, 6);
        write_reg(CFG_MARGIN, 8'($urandom_range(40, 5)));
        write_reg(CFG_TIMEOUT, 8'(tmo));
        queue_random(120, tmo + 2);
        drain();
        queue_random(120, tmo + 2);
        drain();

        // Random settings with timeouts from 2 to 255.
        tmo = $urandom_range(255, 2);
        write_reg(CFG_MARGIN, 8'($urandom_range(80)));
        write_reg(CFG_TIMEOUT, 8'(tmo));
        queue_random(270, (tmo + 2 > 16) ? 16 : tmo + 2);
        drain();

        if (mismatches == 0 && expected_bearings.size() == 0) begin
            $display("vibration_direction_estimator_unit: match");
        end else begin
            $display("vibration_direction_estimator_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: vibration_direction_estimator_unit.f
hw/rtl/vde_pkg.sv
hw/rtl/vde_lane.sv
hw/rtl/vde_tracker.sv
hw/rtl/vibration_direction_estimator_unit.sv
tb/vibration_direction_estimator_unit_tb.sv
